// ----- hw/rtl/fdp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdp_pkg
// Types and constants shared by the four-term dot product pipeline.
// ----------------------------------------------------------------------------
package fdp_pkg;

	localparam int LANES      = 4;
	localparam int MANT_W     = 27;
	localparam int EXP_W      = 10;
	localparam int TOP_W      = 9;
	localparam int SUM_W      = 30;
	localparam int FRAC_W     = 23;

	localparam logic [31:0]        NAN_WORD  = 32'h7F80_0001;
	localparam logic [7:0]         EXP_MAX   = 8'hFF;
	localparam logic [FRAC_W-1:0]  FRAC_ZERO = '0;
	localparam logic [MANT_W-1:0]  INF_MANT  = 27'h200_0000;
	localparam logic signed [EXP_W-1:0] BIAS     = 10'sd127;
	localparam logic signed [EXP_W-1:0] INF_EXP  = 10'sd255;
	localparam logic [10:0]        DROP_DIST = 11'd32;

	// One product term after the multiply stage.
	typedef struct packed {
		logic [MANT_W-1:0]       mant;
		logic signed [EXP_W-1:0] expo;
		logic                    neg;
		logic                    nan;
	} fdp_term_t;

	// Signed sum of the aligned terms with its shared exponent.
	typedef struct packed {
		logic signed [SUM_W-1:0] sum;
		logic [TOP_W-1:0]        top;
		logic                    nan;
	} fdp_sum_t;

endpackage

// ----- hw/rtl/fdp_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdp_in_if / fdp_out_if
// Valid/ready channels carrying operand vectors and the dot product item.
// ----------------------------------------------------------------------------
interface fdp_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] a_word0;
	logic [31:0] a_word1;
	logic [31:0] a_word2;
	logic [31:0] a_word3;
	logic [31:0] b_word0;
	logic [31:0] b_word1;
	logic [31:0] b_word2;
	logic [31:0] b_word3;

	modport source (output valid, a_word0, a_word1, a_word2, a_word3,
		b_word0, b_word1, b_word2, b_word3, input ready);
	modport sink (input valid, a_word0, a_word1, a_word2, a_word3,
		b_word0, b_word1, b_word2, b_word3, output ready);
endinterface

interface fdp_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] dot_word;

	modport source (output valid, dot_word, input ready);
	modport sink (input valid, dot_word, output ready);
endinterface

// ----- hw/rtl/four_term_float_dot_product_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// four_term_float_dot_product_core
// Five-stage pipelined dot product of two four-element single vectors.
// ----------------------------------------------------------------------------
//  Channel    Direction  Payload
//  operands   in         a_word0..a_word3, b_word0..b_word3 (32 bits each)
//  dot        out        dot_word (32 bits)
//
// One item enters per cycle unless a stall on the result channel has filled every stage.
// The stages are multiply, exponent compare, align and sum, leading one,
// and round and pack. Each stage holds its own valid bit, cleared by reset.
// A stall on the result channel holds the stages back only as far as they
// are full, so empty stages keep taking new items.
// ----------------------------------------------------------------------------
module four_term_float_dot_product_core (
	input  logic    clk,
	input  logic    arst_n,
	fdp_in_if.sink  operands,
	fdp_out_if.source dot
);
	import fdp_pkg::*;

	logic [LANES-1:0][31:0]  a_words, b_words;
	fdp_term_t [LANES-1:0]   terms;
	fdp_sum_t                sum;
	logic                    mul_valid, mul_ready;
	logic                    sum_valid, sum_ready;

	assign a_words = {operands.a_word3, operands.a_word2, operands.a_word1, operands.a_word0};
	assign b_words = {operands.b_word3, operands.b_word2, operands.b_word1, operands.b_word0};

	// Multiply stage.
	fdp_mul u_mul (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (operands.valid),
		.in_ready  (operands.ready),
		.a_words   (a_words),
		.b_words   (b_words),
		.out_valid (mul_valid),
		.out_ready (mul_ready),
		.terms     (terms)
	);

	// Alignment and summation stages.
	fdp_align u_align (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (mul_valid),
		.in_ready  (mul_ready),
		.terms     (terms),
		.out_valid (sum_valid),
		.out_ready (sum_ready),
		.result    (sum)
	);

	// Normalisation and packing stages.
	fdp_norm u_norm (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sum_valid),
		.in_ready  (sum_ready),
		.sum_in    (sum),
		.out_valid (dot.valid),
		.out_ready (dot.ready),
		.dot_word  (dot.dot_word)
	);

`ifndef ASSERT_OFF
	// Input back-pressure only arises when the result side is stalled.
	a_stall_source: assert property (@(posedge clk) disable iff (!arst_n)
		!operands.ready |-> (dot.valid && !dot.ready))
		else $error("input stalled without a stalled result");

	// A result with the top exponent is an infinity or the one NaN pattern.
	a_special: assert property (@(posedge clk) disable iff (!arst_n)
		(dot.valid && dot.dot_word[30:23] == EXP_MAX) |->
		(dot.dot_word[22:0] == FRAC_ZERO || dot.dot_word == NAN_WORD))
		else $error("malformed special result");

	// Underflow always flushes to positive zero.
	a_no_subnormal: assert property (@(posedge clk) disable iff (!arst_n)
		(dot.valid && dot.dot_word[30:23] == 8'd0) |-> (dot.dot_word == 32'd0))
		else $error("subnormal or negative zero result");
`endif

endmodule

// ----- hw/rtl/fdp_mul.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdp_mul
// Stage one: decodes the four operand pairs and multiplies the mantissas.
// ----------------------------------------------------------------------------
module fdp_mul (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [fdp_pkg::LANES-1:0][31:0]   a_words,
	input  logic [fdp_pkg::LANES-1:0][31:0]   b_words,
	output logic                              out_valid,
	input  logic                              out_ready,
	output fdp_pkg::fdp_term_t [fdp_pkg::LANES-1:0] terms
);
	import fdp_pkg::*;

	logic                        valid_s1;
	fdp_term_t [LANES-1:0]       term_s1;
	fdp_term_t [LANES-1:0]       term_d;

	// The stage takes a new item when empty or when its item moves on.
	assign in_ready = !valid_s1 || out_ready;

	// Per-lane decode and 24x24 multiply, keeping two guard bits.
	for (genvar i = 0; i < LANES; i++) begin : g_lane
		logic [7:0]  ae, be;
		logic [22:0] af, bf;
		logic [47:0] prod;
		assign ae   = a_words[i][30:23];
		assign be   = b_words[i][30:23];
		assign af   = a_words[i][22:0];
		assign bf   = b_words[i][22:0];
		assign prod = {1'b1, af} * {1'b1, bf};
		always_comb begin
			term_d[i].neg = a_words[i][31] ^ b_words[i][31];
			term_d[i].nan = 1'b0;
			if (ae == EXP_MAX) begin
				term_d[i].nan  = (af != FRAC_ZERO) || (be == '0);
				term_d[i].mant = INF_MANT;
				term_d[i].expo = INF_EXP;
			end else if (be == EXP_MAX) begin
				term_d[i].nan  = (bf != FRAC_ZERO) || (ae == '0);
				term_d[i].mant = INF_MANT;
				term_d[i].expo = INF_EXP;
			end else begin
				term_d[i].mant = prod[47:21];
				term_d[i].expo = $signed({2'b00, ae}) + $signed({2'b00, be}) - BIAS;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			term_s1 <= term_d;
		end
	end

	assign out_valid = valid_s1;
	assign terms     = term_s1;

endmodule

// ----- hw/rtl/fdp_align.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdp_align
// Stages two and three: finds the largest exponent, then aligns and sums.
// ----------------------------------------------------------------------------
module fdp_align (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    in_valid,
	output logic                                    in_ready,
	input  fdp_pkg::fdp_term_t [fdp_pkg::LANES-1:0] terms,
	output logic                                    out_valid,
	input  logic                                    out_ready,
	output fdp_pkg::fdp_sum_t                       result
);
	import fdp_pkg::*;

	logic                          valid_s2, valid_s3;
	logic                          adv_s2, adv_s3;
	logic [LANES-1:0][MANT_W-1:0]  mant_s2;
	logic [LANES-1:0]              neg_s2;
	logic [LANES-1:0]              drop_s2;
	logic [LANES-1:0][4:0]         sh_s2;
	logic [TOP_W-1:0]              top_s2;
	logic                          nan_s2;
	fdp_sum_t                      sum_s3;

	logic signed [EXP_W-1:0]       top_d;
	logic                          nan_d;
	logic                          big_pos, big_neg;
	logic [LANES-1:0][10:0]        gap_d;
	logic signed [SUM_W-1:0]       sum_d;

	assign adv_s3   = !valid_s3 || out_ready;
	assign adv_s2   = !valid_s2 || adv_s3;
	assign in_ready = adv_s2;

	// Largest exponent (never below zero) and the NaN conditions.
	always_comb begin
		top_d   = '0;
		nan_d   = 1'b0;
		big_pos = 1'b0;
		big_neg = 1'b0;
		for (int i = 0; i < LANES; i++) begin
			if (terms[i].expo > top_d) begin
				top_d = terms[i].expo;
			end
			nan_d = nan_d | terms[i].nan;
			if (terms[i].expo >= INF_EXP) begin
				big_pos = big_pos | !terms[i].neg;
				big_neg = big_neg | terms[i].neg;
			end
		end
		nan_d = nan_d | (big_pos & big_neg);
	end

	// Distance of each term below the largest exponent.
	for (genvar i = 0; i < LANES; i++) begin : g_gap
		assign gap_d[i] = 11'($signed({1'b0, top_d}) - $signed({terms[i].expo[EXP_W-1],
			terms[i].expo}));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (adv_s2) begin
				valid_s2 <= in_valid;
			end
			if (adv_s3) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && in_valid) begin
			for (int i = 0; i < LANES; i++) begin
				mant_s2[i] <= terms[i].mant;
				neg_s2[i]  <= terms[i].neg;
				drop_s2[i] <= gap_d[i] >= DROP_DIST;
				sh_s2[i]   <= gap_d[i][4:0];
			end
			top_s2 <= top_d[TOP_W-1:0];
			nan_s2 <= nan_d;
		end
	end

	// Shift each term into place and add them as signed integers.
	always_comb begin
		logic [MANT_W-1:0] aligned;
		sum_d = '0;
		for (int i = 0; i < LANES; i++) begin
			aligned = drop_s2[i] ? '0 : (mant_s2[i] >> sh_s2[i]);
			if (neg_s2[i]) begin
				sum_d = sum_d - $signed({3'b000, aligned});
			end else begin
				sum_d = sum_d + $signed({3'b000, aligned});
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s3 && valid_s2) begin
			sum_s3.sum <= sum_d;
			sum_s3.top <= top_s2;
			sum_s3.nan <= nan_s2;
		end
	end

	assign out_valid = valid_s3;
	assign result    = sum_s3;

endmodule

// ----- hw/rtl/fdp_norm.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdp_norm
// Stages four and five: magnitude and leading one, then round and pack.
// ----------------------------------------------------------------------------
module fdp_norm (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  fdp_pkg::fdp_sum_t sum_in,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [31:0]       dot_word
);
	import fdp_pkg::*;

	logic                  valid_s4, valid_s5;
	logic                  adv_s4, adv_s5;
	logic [MANT_W-1:0]     mag_s4;
	logic [4:0]            msb_s4;
	logic                  sign_s4, zero_s4, nan_s4;
	logic [TOP_W-1:0]      top_s4;
	logic [31:0]           word_s5;

	logic [SUM_W-2:0]      absv;
	logic [MANT_W-1:0]     mag_d;
	logic [4:0]            msb_d;
	logic [31:0]           word_d;

	assign adv_s5   = !valid_s5 || out_ready;
	assign adv_s4   = !valid_s4 || adv_s5;
	assign in_ready = adv_s4;

	// Magnitude with the guard bits dropped, and its leading one.
	always_comb begin
		absv  = sum_in.sum[SUM_W-1] ? (SUM_W-1)'(-sum_in.sum) : sum_in.sum[SUM_W-2:0];
		mag_d = absv[SUM_W-2:2];
		msb_d = '0;
		for (int i = 0; i < MANT_W; i++) begin
			if (mag_d[i]) begin
				msb_d = 5'(i);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			if (adv_s4) begin
				valid_s4 <= in_valid;
			end
			if (adv_s5) begin
				valid_s5 <= valid_s4;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s4 && in_valid) begin
			mag_s4  <= mag_d;
			msb_s4  <= msb_d;
			sign_s4 <= sum_in.sum[SUM_W-1];
			zero_s4 <= (mag_d == '0) || (sum_in.top == '0);
			nan_s4  <= sum_in.nan;
			top_s4  <= sum_in.top;
		end
	end

	// Round half to even once, normalise to 24 bits and pack the word.
	always_comb begin
		logic [1:0]          rsh;
		logic [MANT_W-1:0]   rb;
		logic                up;
		logic [MANT_W:0]     rounded;
		logic [2:0]          nsh;
		logic [MANT_W:0]     shifted;
		logic [4:0]          lsh;
		logic signed [10:0]  expn;
		logic [FRAC_W-1:0]   frac;
		rsh     = '0;
		rb      = '0;
		up      = 1'b0;
		rounded = '0;
		nsh     = '0;
		shifted = '0;
		lsh     = '0;
		if (msb_s4 > 5'd23) begin
			rsh     = 2'(msb_s4 - 5'd23);
			rb      = MANT_W'(1) << (rsh - 2'd1);
			up      = ((mag_s4 & rb) != '0) &&
				(((mag_s4 & (rb << 1)) != '0) || ((mag_s4 & (rb - 1'b1)) != '0));
			rounded = {1'b0, mag_s4} + (up ? {1'b0, rb} : '0);
			nsh     = {1'b0, rsh} + {2'b00, rounded[msb_s4 + 5'd1]};
			shifted = rounded >> nsh;
			expn    = $signed({2'b00, top_s4}) + $signed({8'd0, nsh});
		end else begin
			lsh     = 5'd23 - msb_s4;
			shifted = {1'b0, mag_s4} << lsh;
			expn    = $signed({2'b00, top_s4}) - $signed({6'd0, lsh});
		end
		frac = shifted[FRAC_W-1:0];
		if (nan_s4) begin
			word_d = NAN_WORD;
		end else if (zero_s4) begin
			word_d = '0;
		end else if (expn >= 11'sd255) begin
			word_d = {sign_s4, EXP_MAX, FRAC_ZERO};
		end else if (expn <= 11'sd0) begin
			word_d = '0;
		end else begin
			word_d = {sign_s4, expn[7:0], frac};
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s5 && valid_s4) begin
			word_s5 <= word_d;
		end
	end

	assign out_valid = valid_s5;
	assign dot_word  = word_s5;

endmodule
